>>> hw/rtl/bfs_layer_and_reorder_unit_macros.svh
// Assertion macros shared by the RTL of the layering and reorder unit.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef BFS_LAYER_AND_REORDER_UNIT_MACROS_SVH
`define BFS_LAYER_AND_REORDER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define BFSLR_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define BFSLR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BFSLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BFSLR_ASSERT(lbl, expr, msg)
`define BFSLR_ASSERT_IMP(lbl, ante, cons, msg)
`define BFSLR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/bfslr_pkg.sv
`timescale 1ns / 1ps

package bfslr_pkg;

    typedef logic [1:0] t_opcode;

    localparam t_opcode OP_LEVEL = 2'd0;
    localparam t_opcode OP_EDGE  = 2'd1;
    localparam t_opcode OP_RUN   = 2'd2;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_EDGE   = 1'b1;

    // Hop distances are 7-bit two's complement patterns.
    typedef logic [6:0] t_hop;

    localparam t_hop HOP_ZERO = 7'h00;
    localparam t_hop HOP_NONE = 7'h7F;

    typedef logic [3:0] t_vtx;
    typedef logic [7:0] t_byte;
    typedef logic signed [7:0] t_key;

endpackage

>>> hw/rtl/bfs_layer_and_reorder_unit.sv
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+---------------------------------------
// in       | into unit | i_in_valid / o_in_stall    | i_opcode i_slot i_end_a i_end_b
//          |           |                            | i_col_in i_level_in
// out      | from unit | o_out_valid / i_out_stall  | o_out_kind o_out_index o_out_hops
//          |           |                            | o_out_level o_out_col o_out_last
//
// Load transactions are taken back to back while the unit is idle. A run
// transaction is dominated by the edge visit of every layering sweep, which
// reads the edge list and then both endpoint distances in the states S_BRD,
// S_BHOP and S_BUPD through one sequencer and one compare unit.
// Reset is synchronous and active low; it returns the sequencer to idle. The
// vertex and edge stores are not cleared and hold garbage until loaded.
// o_in_stall is high for the whole run. While a result waits under
// i_out_stall the sequencer holds and does no further work.
`timescale 1ns / 1ps
`include "bfs_layer_and_reorder_unit_macros.svh"

module bfs_layer_and_reorder_unit
    import bfslr_pkg::*;
#(
    parameter int VERTICES = 16,
    parameter int EDGES    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_opcode,
    input  logic [4:0]        i_slot,
    input  logic [3:0]        i_end_a,
    input  logic [3:0]        i_end_b,
    input  logic [7:0]        i_col_in,
    input  logic [7:0]        i_level_in,

    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_out_kind,
    output logic [4:0]        o_out_index,
    output logic signed [6:0] o_out_hops,
    output logic [7:0]        o_out_level,
    output logic [7:0]        o_out_col,
    output logic              o_out_last
);

    // Address and counter widths. The counters cover both stores, so they are
    // sized for the larger one.
    localparam int MAXN = (VERTICES > EDGES) ? VERTICES : EDGES;
    localparam int CW   = $clog2(MAXN);
    localparam int VAW  = $clog2(VERTICES);
    localparam int EAW  = (EDGES > 1) ? $clog2(EDGES) : 1;
    localparam bit EDGE_SORT = (EDGES > 1);

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_HINIT  = 4'd1;
    localparam logic [3:0] S_BRD    = 4'd2;
    localparam logic [3:0] S_BHOP   = 4'd3;
    localparam logic [3:0] S_BUPD   = 4'd4;
    localparam logic [3:0] S_SRD    = 4'd5;
    localparam logic [3:0] S_SHOP   = 4'd6;
    localparam logic [3:0] S_SWR    = 4'd7;
    localparam logic [3:0] S_RI_RD  = 4'd8;
    localparam logic [3:0] S_RI_LD  = 4'd9;
    localparam logic [3:0] S_RJ_CMP = 4'd10;
    localparam logic [3:0] S_RI_WB  = 4'd11;
    localparam logic [3:0] S_ORD    = 4'd12;
    localparam logic [3:0] S_OLD    = 4'd13;
    localparam logic [3:0] S_OWAIT  = 4'd14;

    // Control registers.
    logic [3:0]    r_state, n_state;
    logic          r_eph, n_eph;       // 1 in the edge exchange pass and edge output
    // Datapath registers.
    logic [CW-1:0] r_i, n_i;           // outer index: vertex or edge
    logic [CW-1:0] r_j, n_j;           // inner index of the exchange pass
    logic [EAW-1:0] r_d, n_d;          // current sweep distance
    t_vtx          r_ea, n_ea;
    t_vtx          r_eb, n_eb;
    t_key          r_key, n_key;       // sort key held for the outer entry
    t_byte         r_val, n_val;       // value held for the outer entry
    logic          r_okind, n_okind;
    logic [4:0]    r_oidx, n_oidx;
    t_hop          r_ohops, n_ohops;
    t_byte         r_olvl, n_olvl;
    t_byte         r_ocol, n_ocol;
    logic          r_olast, n_olast;

    // Memory ports.
    logic           lvl_we;
    logic [VAW-1:0] lvl_wa, lvl_ra;
    t_byte          lvl_wd, lvl_rd;
    logic           hop_we;
    logic [VAW-1:0] hop_wa, hop_ra0, hop_ra1;
    t_hop           hop_wd, hop_rd0, hop_rd1;
    logic           end_we;
    logic [EAW-1:0] end_wa, end_ra;
    t_byte          end_wd, end_rd;
    logic           col_we;
    logic [EAW-1:0] col_wa, col_ra;
    t_byte          col_wd, col_rd;
    logic           sum_we;
    logic [EAW-1:0] sum_wa, sum_ra;
    t_byte          sum_wd, sum_rd;

    logic          in_acc;
    logic          out_acc;
    logic [CW-1:0] rd_idx;
    logic [CW-1:0] lim;
    logic          a_in, b_in;
    t_hop          ha, hb, d7;
    t_key          key_rd;
    t_byte         val_rd;
    logic          swap;
    logic          grow_a, grow_b;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OWAIT);

    // An endpoint outside the vertex store is never reached; it reads as -1.
    assign a_in = ({3'b000, r_ea} < 7'(VERTICES));
    assign b_in = ({3'b000, r_eb} < 7'(VERTICES));
    assign ha   = a_in ? hop_rd0 : HOP_NONE;
    assign hb   = b_in ? hop_rd1 : HOP_NONE;
    assign d7   = 7'(r_d);

    // A sweep at distance d extends the layer from one end of an edge to an
    // unreached other end. Both cannot fire at once because d is never -1.
    assign grow_b = (ha == d7) && (hb == HOP_NONE) && b_in;
    assign grow_a = (hb == d7) && (ha == HOP_NONE) && a_in;

    // The exchange pass is one compare-and-swap unit shared by the vertex pass
    // (key hops, value level) and the edge pass (key endpoint sum, value column).
    assign key_rd = r_eph ? t_key'(sum_rd) : t_key'({hop_rd0[6], hop_rd0});
    assign val_rd = r_eph ? col_rd : lvl_rd;
    assign lim    = r_eph ? CW'(EDGES - 1) : CW'(VERTICES - 1);
    assign swap   = (r_key < key_rd) && (r_val < val_rd);

    always_comb begin
        case (r_state)
            S_RI_LD:  rd_idx = r_i + CW'(1);
            S_RJ_CMP: rd_idx = r_j + CW'(1);
            default:  rd_idx = r_i;
        endcase
    end

    // Memory read addresses.
    always_comb begin
        lvl_ra  = VAW'(rd_idx);
        col_ra  = EAW'(rd_idx);
        sum_ra  = EAW'(rd_idx);
        end_ra  = EAW'(r_i);
        hop_ra1 = VAW'(end_rd[7:4]);
        if (r_state inside {S_BHOP, S_SHOP}) begin
            hop_ra0 = VAW'(end_rd[3:0]);
        end else begin
            hop_ra0 = VAW'(rd_idx);
        end
    end

    // Memory writes.
    always_comb begin
        lvl_we = 1'b0;
        lvl_wa = VAW'(i_slot);
        lvl_wd = i_level_in;
        end_we = 1'b0;
        end_wa = EAW'(i_slot);
        end_wd = {i_end_b, i_end_a};
        col_we = 1'b0;
        col_wa = EAW'(i_slot);
        col_wd = i_col_in;
        hop_we = 1'b0;
        hop_wa = VAW'(r_i);
        hop_wd = HOP_NONE;
        sum_we = 1'b0;
        sum_wa = EAW'(r_i);
        sum_wd = t_byte'(t_key'({ha[6], ha}) + t_key'({hb[6], hb}));
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_opcode == OP_LEVEL) && ({2'b00, i_slot} < 7'(VERTICES))) begin
                    lvl_we = 1'b1;
                end
                if (in_acc && (i_opcode == OP_EDGE) && ({2'b00, i_slot} < 7'(EDGES))) begin
                    end_we = 1'b1;
                    col_we = 1'b1;
                end
            end
            S_HINIT: begin
                hop_we = 1'b1;
                hop_wd = (r_i == '0) ? HOP_ZERO : HOP_NONE;
            end
            S_BUPD: begin
                hop_we = grow_a || grow_b;
                hop_wa = grow_b ? VAW'(r_eb) : VAW'(r_ea);
                hop_wd = d7 + 7'd1;
            end
            S_SWR: begin
                sum_we = 1'b1;
            end
            S_RJ_CMP: begin
                if (swap) begin
                    lvl_we = !r_eph;
                    col_we = r_eph;
                end
                lvl_wa = VAW'(r_j);
                lvl_wd = r_val;
                col_wa = EAW'(r_j);
                col_wd = r_val;
            end
            S_RI_WB: begin
                lvl_we = !r_eph;
                col_we = r_eph;
                lvl_wa = VAW'(r_i);
                lvl_wd = r_val;
                col_wa = EAW'(r_i);
                col_wd = r_val;
            end
            default: begin
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_eph   = r_eph;
        n_i     = r_i;
        n_j     = r_j;
        n_d     = r_d;
        n_ea    = r_ea;
        n_eb    = r_eb;
        n_key   = r_key;
        n_val   = r_val;
        n_okind = r_okind;
        n_oidx  = r_oidx;
        n_ohops = r_ohops;
        n_olvl  = r_olvl;
        n_ocol  = r_ocol;
        n_olast = r_olast;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_opcode == OP_RUN)) begin
                    n_state = S_HINIT;
                    n_i     = '0;
                end
            end
            S_HINIT: begin
                if (r_i == CW'(VERTICES - 1)) begin
                    n_state = S_BRD;
                    n_i     = '0;
                    n_d     = '0;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            S_BRD: begin
                n_state = S_BHOP;
            end
            S_BHOP: begin
                n_ea    = end_rd[3:0];
                n_eb    = end_rd[7:4];
                n_state = S_BUPD;
            end
            S_BUPD: begin
                if (r_i == CW'(EDGES - 1)) begin
                    n_i = '0;
                    if (r_d == EAW'(EDGES - 1)) begin
                        n_state = S_RI_RD;
                        n_eph   = 1'b0;
                    end else begin
                        n_d     = r_d + EAW'(1);
                        n_state = S_BRD;
                    end
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_BRD;
                end
            end
            S_SRD: begin
                n_state = S_SHOP;
            end
            S_SHOP: begin
                n_ea    = end_rd[3:0];
                n_eb    = end_rd[7:4];
                n_state = S_SWR;
            end
            S_SWR: begin
                if (r_i == CW'(EDGES - 1)) begin
                    n_i = '0;
                    if (EDGE_SORT) begin
                        n_eph   = 1'b1;
                        n_state = S_RI_RD;
                    end else begin
                        n_eph   = 1'b0;
                        n_state = S_ORD;
                    end
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_SRD;
                end
            end
            S_RI_RD: begin
                n_state = S_RI_LD;
            end
            S_RI_LD: begin
                n_key   = key_rd;
                n_val   = val_rd;
                n_j     = r_i + CW'(1);
                n_state = S_RJ_CMP;
            end
            S_RJ_CMP: begin
                if (swap) begin
                    n_val = val_rd;
                end
                if (r_j == lim) begin
                    n_state = S_RI_WB;
                end else begin
                    n_j = r_j + CW'(1);
                end
            end
            S_RI_WB: begin
                if (r_i == lim - CW'(1)) begin
                    n_i = '0;
                    if (r_eph) begin
                        n_eph   = 1'b0;
                        n_state = S_ORD;
                    end else begin
                        n_state = S_SRD;
                    end
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_RI_RD;
                end
            end
            S_ORD: begin
                n_state = S_OLD;
            end
            S_OLD: begin
                n_oidx = 5'(r_i);
                if (r_eph) begin
                    n_okind = KIND_EDGE;
                    n_ohops = HOP_ZERO;
                    n_olvl  = '0;
                    n_ocol  = col_rd;
                    n_olast = (r_i == CW'(EDGES - 1));
                end else begin
                    n_okind = KIND_VERTEX;
                    n_ohops = hop_rd0;
                    n_olvl  = lvl_rd;
                    n_ocol  = '0;
                    n_olast = 1'b0;
                end
                n_state = S_OWAIT;
            end
            S_OWAIT: begin
                if (out_acc) begin
                    if (r_olast) begin
                        n_state = S_IDLE;
                    end else if (!r_eph && (r_i == CW'(VERTICES - 1))) begin
                        n_eph   = 1'b1;
                        n_i     = '0;
                        n_state = S_ORD;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_eph   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eph   <= n_eph;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_d     <= n_d;
        r_ea    <= n_ea;
        r_eb    <= n_eb;
        r_key   <= n_key;
        r_val   <= n_val;
        r_okind <= n_okind;
        r_oidx  <= n_oidx;
        r_ohops <= n_ohops;
        r_olvl  <= n_olvl;
        r_ocol  <= n_ocol;
        r_olast <= n_olast;
    end

    assign o_out_kind  = r_okind;
    assign o_out_index = r_oidx;
    assign o_out_hops  = r_ohops;
    assign o_out_level = r_olvl;
    assign o_out_col   = r_ocol;
    assign o_out_last  = r_olast;

    // Vertex levels.
    bfslr_ram #(.WIDTH(8), .DEPTH(VERTICES)) u_lvl_ram (
        .i_clk      (i_clk),
        .i_wr_en    (lvl_we),
        .i_wr_addr  (lvl_wa),
        .i_wr_data  (lvl_wd),
        .i_rd_addr0 (lvl_ra),
        .o_rd_data0 (lvl_rd),
        .i_rd_addr1 ('0),
        .o_rd_data1 ()
    );

    // Vertex hop distances; both endpoints of an edge are read together.
    bfslr_ram #(.WIDTH(7), .DEPTH(VERTICES)) u_hop_ram (
        .i_clk      (i_clk),
        .i_wr_en    (hop_we),
        .i_wr_addr  (hop_wa),
        .i_wr_data  (hop_wd),
        .i_rd_addr0 (hop_ra0),
        .o_rd_data0 (hop_rd0),
        .i_rd_addr1 (hop_ra1),
        .o_rd_data1 (hop_rd1)
    );

    // Edge endpoints, end_a in the low nibble.
    bfslr_ram #(.WIDTH(8), .DEPTH(EDGES)) u_end_ram (
        .i_clk      (i_clk),
        .i_wr_en    (end_we),
        .i_wr_addr  (end_wa),
        .i_wr_data  (end_wd),
        .i_rd_addr0 (end_ra),
        .o_rd_data0 (end_rd),
        .i_rd_addr1 ('0),
        .o_rd_data1 ()
    );

    // Edge columns.
    bfslr_ram #(.WIDTH(8), .DEPTH(EDGES)) u_col_ram (
        .i_clk      (i_clk),
        .i_wr_en    (col_we),
        .i_wr_addr  (col_wa),
        .i_wr_data  (col_wd),
        .i_rd_addr0 (col_ra),
        .o_rd_data0 (col_rd),
        .i_rd_addr1 ('0),
        .o_rd_data1 ()
    );

    // Endpoint distance sums, filled once per run before the edge pass.
    bfslr_ram #(.WIDTH(8), .DEPTH(EDGES)) u_sum_ram (
        .i_clk      (i_clk),
        .i_wr_en    (sum_we),
        .i_wr_addr  (sum_wa),
        .i_wr_data  (sum_wd),
        .i_rd_addr0 (sum_ra),
        .o_rd_data0 (sum_rd),
        .i_rd_addr1 ('0),
        .o_rd_data1 ()
    );

    `BFSLR_ASSERT_NEXT(a_run_starts, in_acc && (i_opcode == OP_RUN),
        (r_state == S_HINIT) && (r_i == '0), "run transaction did not start distance init")
    `BFSLR_ASSERT_IMP(a_inner_ahead, r_state == S_RJ_CMP, r_j > r_i,
        "exchange pass inner index not above outer index")
    `BFSLR_ASSERT_IMP(a_last_is_edge, o_out_valid && o_out_last,
        (o_out_kind == KIND_EDGE) && (o_out_index == 5'(EDGES - 1)),
        "last flag on a result other than the final edge")
    `BFSLR_ASSERT_IMP(a_edge_fields, o_out_valid && (o_out_kind == KIND_EDGE),
        (o_out_hops == HOP_ZERO) && (o_out_level == '0), "edge result carries vertex fields")
    `BFSLR_ASSERT_NEXT(a_idle_after_last, out_acc && o_out_last, r_state == S_IDLE,
        "unit not idle after the final result transaction")

endmodule

>>> hw/rtl/bfslr_ram.sv
`timescale 1ns / 1ps

module bfslr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr0,
    output logic [WIDTH-1:0] o_rd_data0,
    input  logic [AW-1:0]    i_rd_addr1,
    output logic [WIDTH-1:0] o_rd_data1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data0;
    logic [WIDTH-1:0] r_rd_data1;

    // Reads return the contents from before a write to the same address.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data0 <= r_mem[i_rd_addr0];
        r_rd_data1 <= r_mem[i_rd_addr1];
    end

    assign o_rd_data0 = r_rd_data0;
    assign o_rd_data1 = r_rd_data1;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the breadth-first layering and reorder unit.
// Load transactions fill the vertex level and edge stores, and each run
// transaction is expected to produce one result per vertex followed by one per
// edge. A predictor inside the bench keeps its own copy of both stores,
// repeats the layering sweeps and the two exchange passes, and queues the
// results it expects. A checker pops that queue for every result transaction
// and compares each field.
module tb
    import bfslr_pkg::*;
();

    localparam int VTX = 16;
    localparam int EDG = 32;
    localparam int ITEM_TARGET = 360;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = 50;
    localparam t_opcode OP_UNUSED = 2'd3;

    typedef struct {
        logic              kind;
        logic [4:0]        index;
        logic signed [6:0] hops;
        logic [7:0]        level;
        logic [7:0]        col;
        logic              last;
    } t_result;

    // Every input of the unit starts from a known value.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic [1:0] i_opcode = OP_UNUSED;
    logic [4:0] i_slot = '0;
    logic [3:0] i_end_a = '0;
    logic [3:0] i_end_b = '0;
    logic [7:0] i_col_in = '0;
    logic [7:0] i_level_in = '0;
    logic i_out_stall = 1'b0;

    logic o_in_stall;
    logic o_out_valid;
    logic o_out_kind;
    logic [4:0] o_out_index;
    logic signed [6:0] o_out_hops;
    logic [7:0] o_out_level;
    logic [7:0] o_out_col;
    logic o_out_last;

    bfs_layer_and_reorder_unit #(
        .VERTICES(VTX),
        .EDGES   (EDG)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_opcode   (i_opcode),
        .i_slot     (i_slot),
        .i_end_a    (i_end_a),
        .i_end_b    (i_end_b),
        .i_col_in   (i_col_in),
        .i_level_in (i_level_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_kind (o_out_kind),
        .o_out_index(o_out_index),
        .o_out_hops (o_out_hops),
        .o_out_level(o_out_level),
        .o_out_col  (o_out_col),
        .o_out_last (o_out_last)
    );

    // Shadow copy of the unit's stores, kept by the predictor.
    logic [7:0] level_mem[VTX];
    int         hop_mem[VTX];
    logic [3:0] end_a_mem[EDG];
    logic [3:0] end_b_mem[EDG];
    logic [7:0] col_mem[EDG];

    t_result layer_results_q[$];
    int      mismatches = 0;
    int      items_sent = 0;
    bit      quiet = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Layering, level exchange and column exchange, in the unit's order, then
    // the expected results of one run transaction are queued.
    task automatic predict_run();
        int d, i, j, a, b, si, sj;
        logic [7:0] t;
        t_result r;
        hop_mem[0] = 0;
        for (i = 1; i < VTX; i++) hop_mem[i] = -1;
        // The second test of each edge sees a distance set by the first one.
        for (d = 0; d < EDG; d++) begin
            for (i = 0; i < EDG; i++) begin
                a = end_a_mem[i];
                b = end_b_mem[i];
                if (hop_mem[a] == d && hop_mem[b] == -1) hop_mem[b] = d + 1;
                if (hop_mem[b] == d && hop_mem[a] == -1) hop_mem[a] = d + 1;
            end
        end
        for (i = 0; i < VTX - 1; i++) begin
            for (j = i + 1; j < VTX; j++) begin
                if (hop_mem[i] < hop_mem[j] && level_mem[i] < level_mem[j]) begin
                    t = level_mem[i];
                    level_mem[i] = level_mem[j];
                    level_mem[j] = t;
                end
            end
        end
        // The endpoint sum of edge i is taken once, before its inner loop.
        for (i = 0; i < EDG - 1; i++) begin
            si = hop_mem[end_a_mem[i]] + hop_mem[end_b_mem[i]];
            for (j = i + 1; j < EDG; j++) begin
                sj = hop_mem[end_a_mem[j]] + hop_mem[end_b_mem[j]];
                if (si < sj && col_mem[i] < col_mem[j]) begin
                    t = col_mem[i];
                    col_mem[i] = col_mem[j];
                    col_mem[j] = t;
                end
            end
        end
        for (i = 0; i < VTX; i++) begin
            r.kind = KIND_VERTEX;
            r.index = 5'(i);
            r.hops = 7'(hop_mem[i]);
            r.level = level_mem[i];
            r.col = '0;
            r.last = 1'b0;
            layer_results_q.push_back(r);
        end
        for (i = 0; i < EDG; i++) begin
            r.kind = KIND_EDGE;
            r.index = 5'(i);
            r.hops = '0;
            r.level = '0;
            r.col = col_mem[i];
            r.last = (i == EDG - 1);
            layer_results_q.push_back(r);
        end
    endtask

    // Mostly back-to-back, sometimes a few idle cycles, rarely a long gap.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [7:0] pick_byte(input bit narrow);
        if (narrow) return 8'($urandom_range(0, 7));
        return 8'($urandom_range(0, 255));
    endfunction

    // Returns {end_b, end_a}. Style 0 is uniform, style 1 follows a path with
    // either orientation, style 2 hangs edges off the first few vertices.
    function automatic logic [7:0] pick_ends(input int style);
        logic [3:0] a, b;
        case (style)
            1: begin
                a = 4'($urandom_range(0, VTX - 2));
                b = a + 4'd1;
                if ($urandom_range(0, 1) == 1) return {a, b};
            end
            2: begin
                a = 4'($urandom_range(0, 3));
                b = 4'($urandom_range(0, VTX - 1));
            end
            default: begin
                a = 4'($urandom_range(0, VTX - 1));
                b = 4'($urandom_range(0, VTX - 1));
            end
        endcase
        return {b, a};
    endfunction

    // Presents one input transaction and waits for it to be taken. Valid stays
    // high afterwards so that a following transaction can go out back to back;
    // the next call lowers it before any idle gap, and a drain lowers it.
    task automatic send_item(input t_opcode op, input logic [4:0] slot,
                             input logic [3:0] ea, input logic [3:0] eb,
                             input logic [7:0] col, input logic [7:0] lvl);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_slot <= slot;
        i_end_a <= ea;
        i_end_b <= eb;
        i_col_in <= col;
        i_level_in <= lvl;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        case (op)
            OP_LEVEL: begin
                // Vertex slots past the store are dropped by the unit.
                if (slot < VTX) begin
                    level_mem[slot] = lvl;
                    items_sent++;
                end
            end
            OP_EDGE: begin
                if (slot < EDG) begin
                    end_a_mem[slot] = ea;
                    end_b_mem[slot] = eb;
                    col_mem[slot] = col;
                    items_sent++;
                end
            end
            OP_RUN: begin
                predict_run();
                items_sent++;
            end
            default: ;
        endcase
    endtask

    task automatic send_level(input logic [4:0] slot, input logic [7:0] lvl);
        send_item(OP_LEVEL, slot, 4'($urandom), 4'($urandom), 8'($urandom), lvl);
    endtask

    task automatic send_edge(input logic [4:0] slot, input logic [7:0] ends,
                             input logic [7:0] col);
        send_item(OP_EDGE, slot, ends[3:0], ends[7:4], col, 8'($urandom));
    endtask

    task automatic send_run();
        send_item(OP_RUN, 5'($urandom), 4'($urandom), 4'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    // Holds the input channel idle until every queued result has arrived.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (layer_results_q.size() != 0);
    endtask

    // Every store entry is written before the first run, so no run ever reads
    // an entry that holds garbage from reset.
    task automatic test_full_load_and_run();
        int i;
        for (i = 0; i < VTX; i++) send_level(5'(i), pick_byte(1'b0));
        for (i = 0; i < EDG; i++) send_edge(5'(i), pick_ends(0), pick_byte(1'b0));
        send_run();
    endtask

    task automatic test_field_extremes();
        send_level(5'd0, 8'd0);
        send_level(5'd15, 8'd255);
        send_level(5'd7, 8'd255);
        send_edge(5'd0, {4'd15, 4'd0}, 8'd255);
        send_edge(5'd31, {4'd15, 4'd15}, 8'd0);
        send_edge(5'd16, {4'd0, 4'd15}, 8'd255);
        send_edge(5'd1, {4'd0, 4'd0}, 8'd0);
        send_run();
    endtask

    // The unused opcode and vertex writes past the store must leave the state
    // alone; the following run shows any damage.
    task automatic test_ignored_items();
        send_item(OP_UNUSED, 5'h1F, 4'hF, 4'hF, 8'hFF, 8'hFF);
        send_item(OP_UNUSED, 5'h00, 4'h0, 4'h0, 8'h00, 8'h00);
        send_item(OP_UNUSED, 5'($urandom), 4'($urandom), 4'($urandom), 8'($urandom),
                  8'($urandom));
        send_level(5'd16, 8'd255);
        send_level(5'd31, 8'd0);
        send_level(5'($urandom_range(VTX, 31)), 8'($urandom));
        send_run();
    endtask

    // Vertex 0 has no edge at all, so every other vertex stays unreached.
    task automatic test_isolated_root();
        int i;
        logic [3:0] a, b;
        for (i = 0; i < EDG; i++) begin
            a = 4'($urandom_range(1, VTX - 1));
            b = 4'($urandom_range(1, VTX - 1));
            send_edge(5'(i), {b, a}, pick_byte(1'b0));
        end
        send_run();
    endtask

    // A path through all vertices, listed from the far end, gives the deepest
    // distances. Rising levels and columns make the exchange passes busy.
    task automatic test_deep_chain();
        int i, k;
        for (i = 0; i < VTX; i++) send_level(5'(i), 8'(i * 16));
        for (i = 0; i < VTX - 1; i++) begin
            send_edge(5'(i), {4'(VTX - 1 - i), 4'(VTX - 2 - i)}, 8'(i * 8));
        end
        // The rest repeat path links with the endpoints swapped.
        for (i = VTX - 1; i < EDG; i++) begin
            k = $urandom_range(0, VTX - 2);
            send_edge(5'(i), {4'(k), 4'(k + 1)}, 8'(i * 8));
        end
        send_run();
    endtask

    // Load bursts with random content, each closed by a run. Some loads hit
    // slots past the store or use the unused opcode.
    task automatic test_random_traffic();
        int loads, r, style;
        bit narrow;
        while (items_sent < ITEM_TARGET) begin
            quiet = ($urandom_range(0, 4) == 0);
            style = $urandom_range(0, 2);
            narrow = 1'($urandom_range(0, 1));
            loads = $urandom_range(0, 20);
            repeat (loads) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    send_level(5'($urandom_range(0, VTX - 1)), pick_byte(narrow));
                end else if (r < 47) begin
                    send_level(5'($urandom_range(VTX, 31)), 8'($urandom));
                end else if (r < 92) begin
                    send_edge(5'($urandom_range(0, EDG - 1)), pick_ends(style),
                              pick_byte(narrow));
                end else begin
                    send_item(OP_UNUSED, 5'($urandom), 4'($urandom), 4'($urandom),
                              8'($urandom), 8'($urandom));
                end
            end
            if ($urandom_range(0, 5) == 0) wait_for_drain();
            send_run();
        end
        quiet = 1'b0;
    endtask

    // Result checker: every result transaction is matched against the oldest
    // queued expectation.
    always @(posedge i_clk) begin : check_results
        t_result want, got;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got.kind = o_out_kind;
            got.index = o_out_index;
            got.hops = o_out_hops;
            got.level = o_out_level;
            got.col = o_out_col;
            got.last = o_out_last;
            if (layer_results_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result with nothing expected: kind=%0d idx=%0d", $time,
                             got.kind, got.index);
                end
            end else begin
                want = layer_results_q.pop_front();
                if (got.kind !== want.kind || got.index !== want.index ||
                    got.hops !== want.hops || got.level !== want.level ||
                    got.col !== want.col || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: expected kind=%0d idx=%0d hops=%0d lvl=%0d col=%0d last=%0d",
                                 $time, want.kind, want.index, want.hops, want.level,
                                 want.col, want.last);
                        $display("%0t: actual   kind=%0d idx=%0d hops=%0d lvl=%0d col=%0d last=%0d",
                                 $time, got.kind, got.index, got.hops, got.level,
                                 got.col, got.last);
                    end
                end
            end
        end
    end

    // Receiver back-pressure: short runs of stall, occasional long ones, and
    // stretches with none at all.
    initial begin : drive_out_stall
        int r;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else if (r < 85) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else if (r < 95) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(20, 100)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end
        end
    end

    initial begin : run_tests
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_full_load_and_run();
        test_field_extremes();
        test_ignored_items();
        test_isolated_root();
        // Let the unit go fully idle once before loading the next graph.
        wait_for_drain();
        test_deep_chain();
        test_random_traffic();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && layer_results_q.size() == 0) begin
            $display("PASS bfs_layer_and_reorder_unit");
        end else begin
            $display("FAIL bfs_layer_and_reorder_unit");
        end
        $finish;
    end

    // Ends the simulation with a failure if the tests do not finish in time.
    initial begin : watchdog
        #10_000_000;
        $display("FAIL bfs_layer_and_reorder_unit");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/bfslr_pkg.sv
hw/rtl/bfslr_ram.sv
hw/rtl/bfs_layer_and_reorder_unit.sv
tb/tb.sv
